@@ hdl/bpc_pkg.sv @@
// ============================================================================
// bpc_pkg: shared types and constants for barometer pressure compensation
// Field widths, calibration register indexes and the stage payload record
// passed between the pipeline sections.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    // Field and datapath widths
    localparam int RAW_W   = 24;                  // raw conversions D1, D2
    localparam int COEF_W  = 16;                  // calibration words
    localparam int CIDX_W  = 3;                   // configuration index
    localparam int DT_W    = RAW_W + 1;           // dT, signed
    localparam int MUL_W   = DT_W + COEF_W + 1;   // dT times a calibration word
    localparam int SQDT_W  = 2 * DT_W;            // dT squared
    localparam int TEMP_W  = 19;                  // temperature, centidegrees
    localparam int TMPX_W  = TEMP_W + 1;          // temperature offsets
    localparam int SQ_W    = 36;                  // second-order squares
    localparam int DD_W    = 18;                  // dT squared >> 31
    localparam int OFF_W   = 41;                  // offset, signed
    localparam int SENS_W  = 40;                  // sensitivity, signed
    localparam int SLO_W   = 20;                  // low slice of SENS
    localparam int PL_W    = RAW_W + SLO_W;       // D1 times low slice
    localparam int PH_W    = RAW_W + 1 + SENS_W - SLO_W; // D1 times high slice
    localparam int PROD_W  = 64;                  // D1 times SENS
    localparam int PRESS_W = 32;                  // pressure output

    // Fixed-point constants
    localparam int TEMP_REF      = 2000;   // 20.00 C
    localparam int TEMP_VCOLD    = 1500;   // -15.00 C, as an offset
    localparam int TEMP_SHIFT    = 23;
    localparam int DD_SHIFT      = 31;
    localparam int OFF_SH_V1     = 7;
    localparam int OFF_SH_V2     = 6;
    localparam int SENS_SH_V1    = 8;
    localparam int SENS_SH_V2    = 7;
    localparam int OFF_BASE_V1   = 16;
    localparam int OFF_BASE_V2   = 17;
    localparam int SENS_BASE_V1  = 15;
    localparam int SENS_BASE_V2  = 16;
    localparam int PRESS_SH1     = 21;
    localparam int PRESS_SH2     = 15;

    // Second-order coefficients
    localparam int OFF_K1_V1  = 5;    // OFF -= 5d >> 1
    localparam int OFF_S1_V1  = 1;
    localparam int OFF_K1_V2  = 61;   // OFF -= 61d >> 4
    localparam int OFF_S1_V2  = 4;
    localparam int SENS_K1_V1 = 5;    // SENS -= 5d >> 2
    localparam int SENS_S1_V1 = 2;
    localparam int SENS_K1_V2 = 2;    // SENS -= 2d
    localparam int OFF_K2_V1  = 7;    // OFF -= 7e
    localparam int OFF_K2_V2  = 15;   // OFF -= 15e
    localparam int SENS_K2_V1 = 11;   // SENS -= 11e >> 1
    localparam int SENS_S2_V1 = 1;
    localparam int SENS_K2_V2 = 8;    // SENS -= 8e

    // Calibration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_SENS     = 3'd0,
        CFG_OFF      = 3'd1,
        CFG_TCS      = 3'd2,
        CFG_TCO      = 3'd3,
        CFG_TREF     = 3'd4,
        CFG_TEMPSENS = 3'd5,
        CFG_VARIANT  = 3'd6
    } t_cfg_idx;

    // Calibration set
    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] off;
        logic [COEF_W-1:0] tcs;
        logic [COEF_W-1:0] tco;
        logic [COEF_W-1:0] tref;
        logic [COEF_W-1:0] tempsens;
        logic              variant;
    } t_cfg;

    // Payload between pipeline sections
    typedef struct packed {
        logic                     valid;
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [DD_W-1:0]          dd;
    } t_comp;

endpackage

`default_nettype wire

@@ hdl/barometer_pressure_compensation.sv @@
// ============================================================================
// barometer_pressure_compensation: second-order compensated pressure and
// temperature from raw 24-bit conversions and six calibration words.
// Each accepted start yields one result strobe at the end of the eight-stage pipeline.
// Throughput: one request per cycle; nothing in the pipeline stalls.
// busy stays low; the receiver cannot stall and every result shows for one cycle.
// Reset (synchronous, active low) clears every valid bit and the calibration set.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module barometer_pressure_compensation (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request channel
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [bpc_pkg::RAW_W-1:0]          i_pressure_raw,
    input  wire logic [bpc_pkg::RAW_W-1:0]          i_temperature_raw,
    // result channel
    output logic                                    o_valid,
    output logic signed [bpc_pkg::PRESS_W-1:0]      o_pressure_pa,
    output logic signed [bpc_pkg::TEMP_W-1:0]       o_temperature_cdeg,
    // configuration channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [bpc_pkg::CIDX_W-1:0]         i_cfg_index,
    input  wire logic [bpc_pkg::COEF_W-1:0]         i_cfg_data
);

    bpc_pkg::t_cfg  w_cfg;
    bpc_pkg::t_comp w_front;
    bpc_pkg::t_comp w_cold;
    logic           w_accept;

    // Fully pipelined: always ready on both channels
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // Calibration registers
    bpc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // First-order terms
    bpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_d1    (i_pressure_raw),
        .i_d2    (i_temperature_raw),
        .i_cfg   (w_cfg),
        .o_comp  (w_front)
    );

    // Low-temperature correction
    bpc_cold u_cold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_variant (w_cfg.variant),
        .i_comp    (w_front),
        .o_comp    (w_cold)
    );

    // Pressure and output registers
    bpc_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_comp  (w_cold),
        .o_valid (o_valid),
        .o_press (o_pressure_pa),
        .o_temp  (o_temperature_cdeg)
    );

endmodule

`default_nettype wire

@@ hdl/bpc_cfg_regs.sv @@
// ============================================================================
// bpc_cfg_regs: calibration register file
// Holds the six calibration words and the device variant bit, written one
// request at a time over the configuration channel.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bpc_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr,
    input  wire logic [bpc_pkg::CIDX_W-1:0] i_idx,
    input  wire logic [bpc_pkg::COEF_W-1:0] i_data,
    output bpc_pkg::t_cfg                   o_cfg
);

    bpc_pkg::t_cfg r_cfg;
    bpc_pkg::t_cfg n_cfg;

    // Decode the register index; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (bpc_pkg::t_cfg_idx'(i_idx))
                bpc_pkg::CFG_SENS:     n_cfg.sens     = i_data;
                bpc_pkg::CFG_OFF:      n_cfg.off      = i_data;
                bpc_pkg::CFG_TCS:      n_cfg.tcs      = i_data;
                bpc_pkg::CFG_TCO:      n_cfg.tco      = i_data;
                bpc_pkg::CFG_TREF:     n_cfg.tref     = i_data;
                bpc_pkg::CFG_TEMPSENS: n_cfg.tempsens = i_data;
                bpc_pkg::CFG_VARIANT:  n_cfg.variant  = i_data[0];
                default:               n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hdl/bpc_front.sv @@
// ============================================================================
// bpc_front: first-order section
// Three stages: dT, the four dT products, then first-order TEMP, OFF and
// SENS with the dT squared term kept for the cold correction.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bpc_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [bpc_pkg::RAW_W-1:0] i_d1,
    input  wire logic [bpc_pkg::RAW_W-1:0] i_d2,
    input  bpc_pkg::t_cfg                  i_cfg,
    output bpc_pkg::t_comp                 o_comp
);

    // Stage 1: dT = D2 - C5 * 256
    logic                              r_v1;
    logic [bpc_pkg::RAW_W-1:0]         r_d1_1;
    logic signed [bpc_pkg::DT_W-1:0]   r_dt;
    logic signed [bpc_pkg::DT_W-1:0]   n_dt;

    assign n_dt = $signed({1'b0, i_d2}) - $signed({1'b0, i_cfg.tref, 8'h00});

    // Stage 2: products with dT
    logic                              r_v2;
    logic [bpc_pkg::RAW_W-1:0]         r_d1_2;
    logic signed [bpc_pkg::MUL_W-1:0]  r_pt;
    logic signed [bpc_pkg::MUL_W-1:0]  r_po;
    logic signed [bpc_pkg::MUL_W-1:0]  r_ps;
    logic signed [bpc_pkg::SQDT_W-1:0] r_pdd;
    logic signed [bpc_pkg::COEF_W:0]   w_c3;
    logic signed [bpc_pkg::COEF_W:0]   w_c4;
    logic signed [bpc_pkg::COEF_W:0]   w_c6;
    logic signed [bpc_pkg::MUL_W-1:0]  n_pt;
    logic signed [bpc_pkg::MUL_W-1:0]  n_po;
    logic signed [bpc_pkg::MUL_W-1:0]  n_ps;
    logic signed [bpc_pkg::SQDT_W-1:0] n_pdd;

    assign w_c3  = $signed({1'b0, i_cfg.tcs});
    assign w_c4  = $signed({1'b0, i_cfg.tco});
    assign w_c6  = $signed({1'b0, i_cfg.tempsens});
    assign n_pt  = r_dt * w_c6;
    assign n_po  = r_dt * w_c4;
    assign n_ps  = r_dt * w_c3;
    assign n_pdd = r_dt * r_dt;

    // Stage 3: first-order TEMP, OFF, SENS
    logic                               r_v3;
    logic [bpc_pkg::RAW_W-1:0]          r_d1_3;
    logic signed [bpc_pkg::TEMP_W-1:0]  r_temp;
    logic signed [bpc_pkg::OFF_W-1:0]   r_off;
    logic signed [bpc_pkg::SENS_W-1:0]  r_sens;
    logic [bpc_pkg::DD_W-1:0]           r_dd;
    logic signed [bpc_pkg::MUL_W-1:0]   w_pt_sh;
    logic signed [bpc_pkg::MUL_W-1:0]   w_po_sh;
    logic signed [bpc_pkg::MUL_W-1:0]   w_ps_sh;
    logic signed [bpc_pkg::OFF_W-1:0]   w_off_base;
    logic signed [bpc_pkg::SENS_W-1:0]  w_sens_base;
    logic signed [bpc_pkg::TEMP_W-1:0]  n_temp;
    logic signed [bpc_pkg::OFF_W-1:0]   n_off;
    logic signed [bpc_pkg::SENS_W-1:0]  n_sens;

    always_comb begin
        w_pt_sh = r_pt >>> bpc_pkg::TEMP_SHIFT;
        if (i_cfg.variant) begin
            w_po_sh     = r_po >>> bpc_pkg::OFF_SH_V2;
            w_ps_sh     = r_ps >>> bpc_pkg::SENS_SH_V2;
            w_off_base  = $signed(bpc_pkg::OFF_W'(i_cfg.off) <<< bpc_pkg::OFF_BASE_V2);
            w_sens_base = $signed(bpc_pkg::SENS_W'(i_cfg.sens) <<< bpc_pkg::SENS_BASE_V2);
        end else begin
            w_po_sh     = r_po >>> bpc_pkg::OFF_SH_V1;
            w_ps_sh     = r_ps >>> bpc_pkg::SENS_SH_V1;
            w_off_base  = $signed(bpc_pkg::OFF_W'(i_cfg.off) <<< bpc_pkg::OFF_BASE_V1);
            w_sens_base = $signed(bpc_pkg::SENS_W'(i_cfg.sens) <<< bpc_pkg::SENS_BASE_V1);
        end
        n_temp = bpc_pkg::TEMP_W'(w_pt_sh) + bpc_pkg::TEMP_W'(bpc_pkg::TEMP_REF);
        n_off  = w_off_base + bpc_pkg::OFF_W'(w_po_sh);
        n_sens = w_sens_base + bpc_pkg::SENS_W'(w_ps_sh);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_d1_1 <= i_d1;
        r_dt   <= n_dt;
        r_d1_2 <= r_d1_1;
        r_pt   <= n_pt;
        r_po   <= n_po;
        r_ps   <= n_ps;
        r_pdd  <= n_pdd;
        r_d1_3 <= r_d1_2;
        r_temp <= n_temp;
        r_off  <= n_off;
        r_sens <= n_sens;
        r_dd   <= r_pdd[bpc_pkg::DD_SHIFT +: bpc_pkg::DD_W];
    end

    assign o_comp.valid = r_v3;
    assign o_comp.d1    = r_d1_3;
    assign o_comp.temp  = r_temp;
    assign o_comp.off   = r_off;
    assign o_comp.sens  = r_sens;
    assign o_comp.dd    = r_dd;

endmodule

`default_nettype wire

@@ hdl/bpc_cold.sv @@
// ============================================================================
// bpc_cold: second-order low-temperature correction
// Two stages: squares of the temperature offsets and cold flags, then the
// OFF, SENS and TEMP corrections for the selected variant.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bpc_cold (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_variant,
    input  bpc_pkg::t_comp i_comp,
    output bpc_pkg::t_comp o_comp
);

    // Stage 4: (TEMP - 2000)^2, (TEMP + 1500)^2 and the range flags
    logic                                r_v4;
    bpc_pkg::t_comp                      r_c4;
    logic [bpc_pkg::SQ_W-1:0]            r_d;
    logic [bpc_pkg::SQ_W-1:0]            r_e;
    logic                                r_cold;
    logic                                r_vcold;
    logic signed [bpc_pkg::TMPX_W-1:0]   w_dlt;
    logic signed [bpc_pkg::TMPX_W-1:0]   w_eb;
    logic signed [2*bpc_pkg::TMPX_W-1:0] w_dsq;
    logic signed [2*bpc_pkg::TMPX_W-1:0] w_esq;

    always_comb begin
        w_dlt = bpc_pkg::TMPX_W'(i_comp.temp) - bpc_pkg::TMPX_W'(bpc_pkg::TEMP_REF);
        w_eb  = bpc_pkg::TMPX_W'(i_comp.temp) + bpc_pkg::TMPX_W'(bpc_pkg::TEMP_VCOLD);
        w_dsq = w_dlt * w_dlt;
        w_esq = w_eb * w_eb;
    end

    // Stage 5: corrections
    logic                               r_v5;
    bpc_pkg::t_comp                     r_c5;
    bpc_pkg::t_comp                     n_c5;
    logic [bpc_pkg::OFF_W-1:0]          w_d;
    logic [bpc_pkg::OFF_W-1:0]          w_e;
    logic [bpc_pkg::OFF_W-1:0]          w_oc1;
    logic [bpc_pkg::OFF_W-1:0]          w_oc2;
    logic [bpc_pkg::OFF_W-1:0]          w_sc1;
    logic [bpc_pkg::OFF_W-1:0]          w_sc2;
    logic signed [bpc_pkg::OFF_W-1:0]   n_off;
    logic signed [bpc_pkg::SENS_W-1:0]  n_sens;
    logic signed [bpc_pkg::TEMP_W-1:0]  n_temp;

    always_comb begin
        w_d = bpc_pkg::OFF_W'(r_d);
        w_e = bpc_pkg::OFF_W'(r_e);
        if (i_variant) begin
            w_oc1 = (w_d * bpc_pkg::OFF_W'(bpc_pkg::OFF_K1_V2)) >> bpc_pkg::OFF_S1_V2;
            w_sc1 = w_d * bpc_pkg::OFF_W'(bpc_pkg::SENS_K1_V2);
            w_oc2 = w_e * bpc_pkg::OFF_W'(bpc_pkg::OFF_K2_V2);
            w_sc2 = w_e * bpc_pkg::OFF_W'(bpc_pkg::SENS_K2_V2);
        end else begin
            w_oc1 = (w_d * bpc_pkg::OFF_W'(bpc_pkg::OFF_K1_V1)) >> bpc_pkg::OFF_S1_V1;
            w_sc1 = (w_d * bpc_pkg::OFF_W'(bpc_pkg::SENS_K1_V1)) >> bpc_pkg::SENS_S1_V1;
            w_oc2 = w_e * bpc_pkg::OFF_W'(bpc_pkg::OFF_K2_V1);
            w_sc2 = (w_e * bpc_pkg::OFF_W'(bpc_pkg::SENS_K2_V1)) >> bpc_pkg::SENS_S2_V1;
        end
        // very cold only ever comes with cold
        if (!r_cold) begin
            w_oc1 = '0;
            w_sc1 = '0;
        end
        if (!r_vcold) begin
            w_oc2 = '0;
            w_sc2 = '0;
        end
        n_off  = $signed(r_c4.off - w_oc1 - w_oc2);
        n_sens = $signed(r_c4.sens - bpc_pkg::SENS_W'(w_sc1) - bpc_pkg::SENS_W'(w_sc2));
        n_temp = r_cold ? $signed(r_c4.temp - bpc_pkg::TEMP_W'(r_c4.dd)) : r_c4.temp;
        n_c5      = r_c4;
        n_c5.temp = n_temp;
        n_c5.off  = n_off;
        n_c5.sens = n_sens;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v4 <= i_comp.valid;
            r_v5 <= r_v4;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_c4    <= i_comp;
        r_d     <= w_dsq[bpc_pkg::SQ_W-1:0];
        r_e     <= w_esq[bpc_pkg::SQ_W-1:0];
        r_cold  <= w_dlt[bpc_pkg::TMPX_W-1];
        r_vcold <= w_eb[bpc_pkg::TMPX_W-1];
        r_c5    <= n_c5;
    end

    always_comb begin
        o_comp       = r_c5;
        o_comp.valid = r_v5;
    end

endmodule

`default_nettype wire

@@ hdl/bpc_press.sv @@
// ============================================================================
// bpc_press: pressure section
// Three stages: D1 times SENS as two partial products, their sum, then the
// offset subtraction and final shifts into the output registers.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bpc_press (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  bpc_pkg::t_comp                          i_comp,
    output logic                                    o_valid,
    output logic signed [bpc_pkg::PRESS_W-1:0]      o_press,
    output logic signed [bpc_pkg::TEMP_W-1:0]       o_temp
);

    // Stage 6: partial products of D1 and SENS
    logic                                     r_v6;
    logic [bpc_pkg::PL_W-1:0]                 r_pl;
    logic signed [bpc_pkg::PH_W-1:0]          r_ph;
    logic signed [bpc_pkg::OFF_W-1:0]         r_off6;
    logic signed [bpc_pkg::TEMP_W-1:0]        r_temp6;
    logic [bpc_pkg::SLO_W-1:0]                w_lo;
    logic signed [bpc_pkg::SENS_W-bpc_pkg::SLO_W-1:0] w_hi;
    logic [bpc_pkg::PL_W-1:0]                 n_pl;
    logic signed [bpc_pkg::PH_W-1:0]          n_ph;

    always_comb begin
        w_lo = i_comp.sens[bpc_pkg::SLO_W-1:0];
        w_hi = $signed(i_comp.sens[bpc_pkg::SENS_W-1:bpc_pkg::SLO_W]);
        n_pl = i_comp.d1 * w_lo;
        n_ph = $signed({1'b0, i_comp.d1}) * w_hi;
    end

    // Stage 7: D1 * SENS
    logic                                r_v7;
    logic signed [bpc_pkg::PROD_W-1:0]   r_prod;
    logic signed [bpc_pkg::OFF_W-1:0]    r_off7;
    logic signed [bpc_pkg::TEMP_W-1:0]   r_temp7;
    logic signed [bpc_pkg::PROD_W-1:0]   n_prod;

    assign n_prod = $signed((bpc_pkg::PROD_W'(r_ph) <<< bpc_pkg::SLO_W)
                            + bpc_pkg::PROD_W'(r_pl));

    // Stage 8: ((D1 * SENS >> 21) - OFF) >> 15
    logic                                r_v8;
    logic signed [bpc_pkg::PRESS_W-1:0]  r_press;
    logic signed [bpc_pkg::TEMP_W-1:0]   r_temp8;
    logic signed [bpc_pkg::PROD_W-1:0]   w_x;
    logic signed [bpc_pkg::PROD_W-1:0]   w_xs;

    always_comb begin
        w_x  = (r_prod >>> bpc_pkg::PRESS_SH1) - bpc_pkg::PROD_W'(r_off7);
        w_xs = w_x >>> bpc_pkg::PRESS_SH2;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            r_v6 <= i_comp.valid;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_pl    <= n_pl;
        r_ph    <= n_ph;
        r_off6  <= i_comp.off;
        r_temp6 <= i_comp.temp;
        r_prod  <= n_prod;
        r_off7  <= r_off6;
        r_temp7 <= r_temp6;
        r_press <= bpc_pkg::PRESS_W'(w_xs);
        r_temp8 <= r_temp7;
    end

    assign o_valid = r_v8;
    assign o_press = r_press;
    assign o_temp  = r_temp8;

endmodule

`default_nettype wire

@@ hdl/bpc_checker.sv @@
// ============================================================================
// bpc_checker: port-level checks for barometer pressure compensation
// Request to result timing, reset clearing and constant readiness.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bpc_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic                               o_valid,
    input wire logic                               i_cfg_valid,
    input wire logic                               o_cfg_ready
);

    // Every accepted request yields a result strobe
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##8 o_valid)
        else $error("accepted request produced no result");

    // No result without a matching earlier request
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, 8))
        else $error("result strobe without matching request");

    // Reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // Both channels always take a request
    a_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start || i_cfg_valid) |-> (!busy && o_cfg_ready))
        else $error("request refused");

endmodule

bind barometer_pressure_compensation bpc_checker u_bpc_checker (.*);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ============================================================================
// testbench: barometer pressure compensation
// Drives raw pressure and temperature conversions under several calibration
// sets and both device variants, predicts the compensated pressure and
// temperature in 64-bit fixed point and checks every result strobe in order.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 4;
    localparam int PIPE_DEPTH     = 8;
    localparam int STALL_LIMIT    = 1000;
    localparam int PRINT_LIMIT    = 40;
    localparam int SETS_PER_PHASE = 4;
    localparam int ITEMS_PER_SET  = 152;

    // index with no register behind it
    localparam logic [bpc_pkg::CIDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [bpc_pkg::RAW_W-1:0]  RAW_MAX   = '1;
    localparam logic [bpc_pkg::COEF_W-1:0] COEF_MAX  = '1;
    localparam logic [bpc_pkg::RAW_W-1:0]  TYP_D1    = 24'd9085466;
    localparam logic [bpc_pkg::RAW_W-1:0]  TYP_D2    = 24'd8569150;

    typedef struct {
        logic signed [bpc_pkg::PRESS_W-1:0] press;
        logic signed [bpc_pkg::TEMP_W-1:0]  temp;
    } t_reading;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic [bpc_pkg::RAW_W-1:0]          i_pressure_raw;
    logic [bpc_pkg::RAW_W-1:0]          i_temperature_raw;
    logic                               o_valid;
    logic signed [bpc_pkg::PRESS_W-1:0] o_pressure_pa;
    logic signed [bpc_pkg::TEMP_W-1:0]  o_temperature_cdeg;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [bpc_pkg::CIDX_W-1:0]         i_cfg_index;
    logic [bpc_pkg::COEF_W-1:0]         i_cfg_data;

    bpc_pkg::t_cfg calib;                 // calibration set as the block should hold it
    t_reading      pending_readings[$];   // predicted results, oldest first
    int            idle_pct;
    int            mismatch_count;
    int            quiet_cycles;

    barometer_pressure_compensation u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_pressure_raw     (i_pressure_raw),
        .i_temperature_raw  (i_temperature_raw),
        .o_valid            (o_valid),
        .o_pressure_pa      (o_pressure_pa),
        .o_temperature_cdeg (o_temperature_cdeg),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Second-order compensation, all in 64-bit signed arithmetic; >>> floors
    function automatic t_reading compensate(input logic [bpc_pkg::RAW_W-1:0] d1,
                                            input logic [bpc_pkg::RAW_W-1:0] d2);
        t_reading r;
        longint   p_raw, t_raw, c1, c2, c3, c4, c5, c6;
        longint   dt, off, sens, temp, sq, press;
        p_raw = d1;
        t_raw = d2;
        c1    = calib.sens;
        c2    = calib.off;
        c3    = calib.tcs;
        c4    = calib.tco;
        c5    = calib.tref;
        c6    = calib.tempsens;
        dt    = t_raw - c5 * 256;
        if (calib.variant) begin
            off  = c2 * 131072 + ((c4 * dt) >>> 6);
            sens = c1 * 65536  + ((c3 * dt) >>> 7);
        end else begin
            off  = c2 * 65536 + ((c4 * dt) >>> 7);
            sens = c1 * 32768 + ((c3 * dt) >>> 8);
        end
        temp = 2000 + ((dt * c6) >>> 23);
        // below 20.00 C, using the uncorrected temperature
        if (temp < 2000) begin
            sq = (temp - 2000) * (temp - 2000);
            if (calib.variant) begin
                off  = off - ((61 * sq) >>> 4);
                sens = sens - 2 * sq;
            end else begin
                off  = off - ((5 * sq) >>> 1);
                sens = sens - ((5 * sq) >>> 2);
            end
            // below -15.00 C, extra term
            if (temp < -1500) begin
                sq = (temp + 1500) * (temp + 1500);
                if (calib.variant) begin
                    off  = off - 15 * sq;
                    sens = sens - 8 * sq;
                end else begin
                    off  = off - 7 * sq;
                    sens = sens - ((11 * sq) >>> 1);
                end
            end
            temp = temp - ((dt * dt) >>> 31);
        end
        press   = (((p_raw * sens) >>> 21) - off) >>> 15;
        r.press = press[bpc_pkg::PRESS_W-1:0];
        r.temp  = temp[bpc_pkg::TEMP_W-1:0];
        return r;
    endfunction

    // Raw temperature that lands the first-order temperature about drop
    // centidegrees below 20 C, moved by nudge counts; clamped to the field
    function automatic logic [bpc_pkg::RAW_W-1:0] raw_temp_near(input longint drop,
                                                                input longint nudge);
        longint c6, d2;
        c6 = calib.tempsens;
        d2 = longint'(calib.tref) * 256 + nudge;
        if (c6 != 0)
            d2 = d2 - (drop * 8388608) / c6;
        if (d2 < 0)
            d2 = 0;
        if (d2 > longint'(RAW_MAX))
            d2 = longint'(RAW_MAX);
        return d2[bpc_pkg::RAW_W-1:0];
    endfunction

    function automatic logic [bpc_pkg::COEF_W-1:0] pick_coef();
        case ($urandom_range(9))
            0:       return '0;
            1:       return COEF_MAX;
            default: return bpc_pkg::COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [bpc_pkg::RAW_W-1:0] pick_pressure();
        case ($urandom_range(7))
            0:       return '0;
            1:       return RAW_MAX;
            default: return bpc_pkg::RAW_W'($urandom);
        endcase
    endfunction

    // Mix of full-range values and values around the two temperature thresholds
    function automatic logic [bpc_pkg::RAW_W-1:0] pick_temperature();
        case ($urandom_range(9))
            4, 5:    return raw_temp_near(0, longint'($urandom_range(8192)) - 4096);
            6, 7:    return raw_temp_near(3500, longint'($urandom_range(128)) - 64);
            8:       return $urandom_range(1) ? RAW_MAX : '0;
            default: return bpc_pkg::RAW_W'($urandom);
        endcase
    endfunction

    function automatic bpc_pkg::t_cfg typical_calib(input logic variant);
        bpc_pkg::t_cfg c;
        c.sens     = 16'd40127;
        c.off      = 16'd36924;
        c.tcs      = 16'd23317;
        c.tco      = 16'd23282;
        c.tref     = 16'd33464;
        c.tempsens = 16'd28312;
        c.variant  = variant;
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns  mismatch: %s", $time, what);
    endtask

    // One request; random idle cycles ahead of it, start kept high otherwise
    task automatic send_sample(input logic [bpc_pkg::RAW_W-1:0] d1,
                               input logic [bpc_pkg::RAW_W-1:0] d2);
        t_reading want;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start             <= 1'b1;
        i_pressure_raw    <= d1;
        i_temperature_raw <= d2;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = compensate(d1, d2);
        pending_readings.push_back(want);
    endtask

    // Stop requests and let the pipeline empty
    task automatic settle();
        start <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // One register write; valid is left high for a following write
    task automatic cfg_write(input logic [bpc_pkg::CIDX_W-1:0] idx,
                             input logic [bpc_pkg::COEF_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            bpc_pkg::CFG_SENS:     calib.sens     = data;
            bpc_pkg::CFG_OFF:      calib.off      = data;
            bpc_pkg::CFG_TCS:      calib.tcs      = data;
            bpc_pkg::CFG_TCO:      calib.tco      = data;
            bpc_pkg::CFG_TREF:     calib.tref     = data;
            bpc_pkg::CFG_TEMPSENS: calib.tempsens = data;
            bpc_pkg::CFG_VARIANT:  calib.variant  = data[0];
            default:               ;
        endcase
    endtask

    // Full calibration load; variant word carries random unused upper bits
    task automatic load_calibration(input bpc_pkg::t_cfg set);
        logic [bpc_pkg::COEF_W-1:0] variant_word;
        variant_word    = bpc_pkg::COEF_W'($urandom);
        variant_word[0] = set.variant;
        settle();
        cfg_write(bpc_pkg::CFG_SENS, set.sens);
        cfg_write(bpc_pkg::CFG_OFF, set.off);
        cfg_write(bpc_pkg::CFG_TCS, set.tcs);
        cfg_write(bpc_pkg::CFG_TCO, set.tco);
        cfg_write(bpc_pkg::CFG_TREF, set.tref);
        cfg_write(bpc_pkg::CFG_TEMPSENS, set.tempsens);
        cfg_write(CFG_SPARE, bpc_pkg::COEF_W'($urandom));
        cfg_write(bpc_pkg::CFG_VARIANT, variant_word);
        i_cfg_valid <= 1'b0;
    endtask

    // All calibration words zero out of reset
    task automatic test_reset_state();
        idle_pct = 0;
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(TYP_D1, '0);
    endtask

    // Warm, 20 C edge, cold, -15 C edge, very cold, in both variants
    task automatic test_warm_and_cold();
        int v;
        idle_pct = 0;
        for (v = 0; v < 2; v++) begin
            load_calibration(typical_calib(v[0]));
            send_sample(TYP_D1, TYP_D2);
            send_sample(TYP_D1, raw_temp_near(0, 0));
            send_sample(TYP_D1, raw_temp_near(0, -1));
            send_sample(TYP_D1, raw_temp_near(1700, 0));
            send_sample(TYP_D1, raw_temp_near(3500, 0));
            send_sample(TYP_D1, raw_temp_near(3500, -300));
            send_sample(RAW_MAX, '0);
            send_sample('0, RAW_MAX);
        end
    endtask

    // Every calibration word at full scale
    task automatic test_extreme_calibration();
        bpc_pkg::t_cfg set;
        set.sens     = COEF_MAX;
        set.off      = COEF_MAX;
        set.tcs      = COEF_MAX;
        set.tco      = COEF_MAX;
        set.tref     = COEF_MAX;
        set.tempsens = COEF_MAX;
        set.variant  = 1'b1;
        load_calibration(set);
        send_sample(RAW_MAX, '0);
        send_sample(RAW_MAX, RAW_MAX);
        set.variant = 1'b0;
        load_calibration(set);
        send_sample(RAW_MAX, '0);
    endtask

    // Only bit 0 of the variant register counts
    task automatic test_variant_masking();
        load_calibration(typical_calib(1'b1));
        cfg_write(bpc_pkg::CFG_VARIANT, 16'hFFFE);
        i_cfg_valid <= 1'b0;
        send_sample(TYP_D1, raw_temp_near(3500, -300));
        settle();
        cfg_write(bpc_pkg::CFG_VARIANT, 16'h0001);
        i_cfg_valid <= 1'b0;
        send_sample(TYP_D1, raw_temp_near(3500, -300));
    endtask

    // Random calibration sets and samples at one idle rate
    task automatic test_random_samples(input int pct);
        bpc_pkg::t_cfg set;
        int            s, n;
        for (s = 0; s < SETS_PER_PHASE; s++) begin
            set.sens     = pick_coef();
            set.off      = pick_coef();
            set.tcs      = pick_coef();
            set.tco      = pick_coef();
            set.tref     = pick_coef();
            set.tempsens = pick_coef();
            set.variant  = 1'($urandom_range(1));
            load_calibration(set);
            idle_pct = pct;
            for (n = 0; n < ITEMS_PER_SET; n++)
                send_sample(pick_pressure(), pick_temperature());
        end
    endtask

    // Test sequence
    initial begin
        i_rst_n           <= 1'b0;
        start             <= 1'b0;
        i_pressure_raw    <= '0;
        i_temperature_raw <= '0;
        i_cfg_valid       <= 1'b0;
        i_cfg_index       <= '0;
        i_cfg_data        <= '0;
        calib              = '0;
        idle_pct           = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_warm_and_cold();
        test_extreme_calibration();
        test_variant_masking();
        test_random_samples(0);
        test_random_samples(55);
        test_random_samples(22);
        settle();

        if (mismatch_count == 0)
            $display("** barometer_pressure_compensation: PASSED **");
        else
            $display("** barometer_pressure_compensation: FAILED **");
        $finish;
    end

    // Result checker: each strobe against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_reading want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_readings.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: pa %0d cdeg %0d",
                                          o_pressure_pa, o_temperature_cdeg));
            end else begin
                want = pending_readings.pop_front();
                if (o_pressure_pa !== want.press)
                    report_mismatch($sformatf("pressure_pa got %0d want %0d",
                                              o_pressure_pa, want.press));
                if (o_temperature_cdeg !== want.temp)
                    report_mismatch($sformatf("temperature_cdeg got %0d want %0d",
                                              o_temperature_cdeg, want.temp));
            end
        end
    end

    // Watchdog: too long without any request, result or register write
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** barometer_pressure_compensation: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
